// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/crc8fr_pkg.sv =====
package crc8fr_pkg;

   localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

   typedef enum logic [1:0] {
      REG_START = 2'd0,
      REG_STOP  = 2'd1,
      REG_FILL  = 2'd2,
      REG_CHECK = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic       good;
      logic [7:0] fill;
      logic [7:0] check;
   } pkt_desc_type;

   typedef struct packed {
      logic wr_en;
      logic commit;
   } front_req_type;

   typedef struct packed {
      logic rd_en;
      logic release_slot;
   } back_req_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY_REFL;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/crc8_framed_packet_receiver.sv =====
// Framed packet receiver with CRC-8/Maxim check.
// Request channel: one received byte per request, taken when push is high and
// full is low. Bytes are dropped until the start byte, then DATA_BYTES data
// bytes and one check byte are stored as they come, then bytes are dropped
// until the stop byte. The front takes one byte per cycle while full is low.
// Result channel: on the stop byte the packet comes out as DATA_BYTES+1
// results, the check byte last with last set; on a CRC mismatch the data bytes
// read as the fill value and the check byte as its replacement.
// Each result goes through the registered packet memory read and the single
// output register; the next read is issued only once the current result has
// been popped.
// Two packets may wait in the memory; with both waiting, full is high until
// the older one has been read out. A stalled pop holds the current result and
// stops further reads; the front keeps taking bytes until the memory is full.
// Reset clears framing state, the packet queue and the output; registers reset
// to start 0xFF, stop 0xFE, fill 0x00, check replacement 0xA9.
// Registers over the APB port at byte addresses 0, 4, 8 and 12.
module crc8_framed_packet_receiver #(
   parameter int DATA_BYTES = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_rx_byte,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_check_byte,
   output logic        rsp_crc_good,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import crc8fr_pkg::*;

   localparam int CW = $clog2(DATA_BYTES + 1);

   logic [7:0]    start_ff, stop_ff, fill_ff, check_ff;
   logic [7:0]    rd_reg;
   logic          csr_wr;
   reg_index_type csr_idx;

   front_req_type freq;
   back_req_type  breq;
   pkt_desc_type  wr_desc, rd_desc;
   logic [CW-1:0] wr_idx, rd_idx;
   logic [7:0]    wr_data, rd_data;
   logic          q_full, q_avail;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = reg_index_type'(paddr[3:2]);

   always_comb begin
      case (csr_idx)
         REG_START: rd_reg = start_ff;
         REG_STOP:  rd_reg = stop_ff;
         REG_FILL:  rd_reg = fill_ff;
         REG_CHECK: rd_reg = check_ff;
         default:   rd_reg = 8'd0;
      endcase
   end

   assign prdata = {24'd0, rd_reg};

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 8'hFF;
         stop_ff  <= 8'hFE;
         fill_ff  <= 8'h00;
         check_ff <= 8'hA9;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_START: start_ff <= pwdata[7:0];
            REG_STOP:  stop_ff  <= pwdata[7:0];
            REG_FILL:  fill_ff  <= pwdata[7:0];
            REG_CHECK: check_ff <= pwdata[7:0];
            default:   start_ff <= start_ff;
         endcase
      end
   end

   crc8fr_front #(.DATA_BYTES(DATA_BYTES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .rx_byte    (req_rx_byte),
      .start_byte (start_ff),
      .stop_byte  (stop_ff),
      .fill_byte  (fill_ff),
      .check_byte (check_ff),
      .q_full     (q_full),
      .freq       (freq),
      .wr_idx     (wr_idx),
      .wr_data    (wr_data),
      .desc       (wr_desc)
   );

   crc8fr_queue #(.DATA_BYTES(DATA_BYTES)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .freq    (freq),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .wr_desc (wr_desc),
      .full    (q_full),
      .breq    (breq),
      .rd_idx  (rd_idx),
      .avail   (q_avail),
      .rd_desc (rd_desc),
      .rd_data (rd_data)
   );

   crc8fr_back #(.DATA_BYTES(DATA_BYTES)) u_back (
      .clock             (clock),
      .reset             (reset),
      .avail             (q_avail),
      .desc              (rd_desc),
      .rd_data           (rd_data),
      .breq              (breq),
      .rd_idx            (rd_idx),
      .empty             (empty),
      .pop               (pop),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_is_check_byte (rsp_is_check_byte),
      .rsp_crc_good      (rsp_crc_good),
      .rsp_last          (rsp_last)
   );

endmodule

// ===== rtl/core/crc8fr_front.sv =====
module crc8fr_front #(
   parameter int DATA_BYTES = 10,
   localparam int CW = $clog2(DATA_BYTES + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic [7:0]                rx_byte,
   input  logic [7:0]                start_byte,
   input  logic [7:0]                stop_byte,
   input  logic [7:0]                fill_byte,
   input  logic [7:0]                check_byte,
   input  logic                      q_full,
   output crc8fr_pkg::front_req_type freq,
   output logic [CW-1:0]             wr_idx,
   output logic [7:0]                wr_data,
   output crc8fr_pkg::pkt_desc_type  desc
);
   import crc8fr_pkg::*;

   localparam logic [CW-1:0] LAST = CW'(DATA_BYTES);

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_DATA = 2'd1,
      PH_STOP = 2'd2
   } phase_type;

   phase_type     phase_ff, phase_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [7:0]    crc_ff, crc_in;
   logic          good_ff, good_in;
   logic          accept;

   assign full    = q_full;
   assign accept  = push && !q_full;
   assign wr_idx  = cnt_ff;
   assign wr_data = rx_byte;
   assign desc    = '{good: good_ff, fill: fill_byte, check: check_byte};

   always_comb begin
      phase_in    = phase_ff;
      cnt_in      = cnt_ff;
      crc_in      = crc_ff;
      good_in     = good_ff;
      freq.wr_en  = 1'b0;
      freq.commit = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_DATA: begin
               freq.wr_en = 1'b1;
               if (cnt_ff == LAST) begin
                  good_in  = (crc_ff == rx_byte);
                  cnt_in   = '0;
                  phase_in = PH_STOP;
               end else begin
                  crc_in = crc8_update(crc_ff, rx_byte);
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            PH_STOP: begin
               if (rx_byte == stop_byte) begin
                  freq.commit = 1'b1;
                  phase_in    = PH_HUNT;
               end
            end
            default: begin
               phase_in = PH_HUNT;
               if (rx_byte == start_byte) begin
                  phase_in = PH_DATA;
                  cnt_in   = '0;
                  crc_in   = '0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         cnt_ff   <= '0;
         crc_ff   <= '0;
         good_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         crc_ff   <= crc_in;
         good_ff  <= good_in;
      end
   end

endmodule

// ===== rtl/core/crc8fr_queue.sv =====
`include "assert_macros.svh"

module crc8fr_queue #(
   parameter int DATA_BYTES = 10,
   localparam int CW = $clog2(DATA_BYTES + 1),
   localparam int DEPTH = 2 * (DATA_BYTES + 1),
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  crc8fr_pkg::front_req_type freq,
   input  logic [CW-1:0]             wr_idx,
   input  logic [7:0]                wr_data,
   input  crc8fr_pkg::pkt_desc_type  wr_desc,
   output logic                      full,
   input  crc8fr_pkg::back_req_type  breq,
   input  logic [CW-1:0]             rd_idx,
   output logic                      avail,
   output crc8fr_pkg::pkt_desc_type  rd_desc,
   output logic [7:0]                rd_data
);
   import crc8fr_pkg::*;

   localparam logic [AW-1:0] SLOT_BASE = AW'(DATA_BYTES + 1);

   logic [7:0]   mem_ff [DEPTH];
   logic [7:0]   rdata_ff;
   pkt_desc_type desc_ff [2];
   logic         wr_slot_ff, rd_slot_ff;
   logic [1:0]   count_ff, count_in;
   logic [AW-1:0] wr_addr, rd_addr;

   assign wr_addr = (wr_slot_ff ? SLOT_BASE : '0) + AW'(wr_idx);
   assign rd_addr = (rd_slot_ff ? SLOT_BASE : '0) + AW'(rd_idx);
   assign full    = (count_ff == 2'd2);
   assign avail   = (count_ff != 2'd0);
   assign rd_desc = desc_ff[rd_slot_ff];
   assign rd_data = rdata_ff;

   always_comb begin
      case ({freq.commit, breq.release_slot})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (freq.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (breq.rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
      if (freq.commit) begin
         desc_ff[wr_slot_ff] <= wr_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_slot_ff <= 1'b0;
         rd_slot_ff <= 1'b0;
         count_ff   <= 2'd0;
      end else begin
         if (freq.commit) begin
            wr_slot_ff <= !wr_slot_ff;
         end
         if (breq.release_slot) begin
            rd_slot_ff <= !rd_slot_ff;
         end
         count_ff <= count_in;
      end
   end

   `ASSERT_IMPL(a_count_range, clock, reset, 1'b1, count_ff != 2'd3)
   `ASSERT_IMPL(a_no_commit_full, clock, reset, freq.commit, count_ff != 2'd2)
   `ASSERT_IMPL(a_no_release_empty, clock, reset, breq.release_slot, count_ff != 2'd0)

endmodule

// ===== rtl/core/crc8fr_back.sv =====
`include "assert_macros.svh"

module crc8fr_back #(
   parameter int DATA_BYTES = 10,
   localparam int CW = $clog2(DATA_BYTES + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     avail,
   input  crc8fr_pkg::pkt_desc_type desc,
   input  logic [7:0]               rd_data,
   output crc8fr_pkg::back_req_type breq,
   output logic [CW-1:0]            rd_idx,
   output logic                     empty,
   input  logic                     pop,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_is_check_byte,
   output logic                     rsp_crc_good,
   output logic                     rsp_last
);
   import crc8fr_pkg::*;

   localparam logic [CW-1:0] LAST = CW'(DATA_BYTES);

   logic          busy_ff, pend_ff, out_valid_ff;
   logic          chk_pend_ff;
   logic [CW-1:0] idx_ff;
   pkt_desc_type  desc_ff;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic          out_chk_ff, out_good_ff;
   logic          issue, start;

   assign start  = !busy_ff && avail;
   assign issue  = busy_ff && !pend_ff && !out_valid_ff;

   assign breq.rd_en        = issue;
   assign breq.release_slot = issue && (idx_ff == LAST);
   assign rd_idx            = idx_ff;

   assign empty             = !out_valid_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_is_check_byte = out_chk_ff;
   assign rsp_crc_good      = out_good_ff;
   assign rsp_last          = out_chk_ff;

   always_comb begin
      if (desc_ff.good) begin
         out_byte_in = rd_data;
      end else if (chk_pend_ff) begin
         out_byte_in = desc_ff.check;
      end else begin
         out_byte_in = desc_ff.fill;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         if (start) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (issue) begin
            if (idx_ff == LAST) begin
               busy_ff <= 1'b0;
            end
            idx_ff <= idx_ff + 1'b1;
         end
         pend_ff <= issue;
         if (pend_ff) begin
            out_valid_ff <= 1'b1;
         end else if (pop && out_valid_ff) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         desc_ff <= desc;
      end
      if (issue) begin
         chk_pend_ff <= (idx_ff == LAST);
      end
      if (pend_ff) begin
         out_byte_ff <= out_byte_in;
         out_chk_ff  <= chk_pend_ff;
         out_good_ff <= desc_ff.good;
      end
   end

   `ASSERT_NEXT(a_load_shows, clock, reset, pend_ff, !empty)

endmodule
